@@ rtl/candidate_key_dedup_ring_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the candidate key dedup ring
// Implication checks on clk_i with reset as disable; empty when assertions
// are compiled out.
// ----------------------------------------------------------------------------
`ifndef CANDIDATE_KEY_DEDUP_RING_CORE_ASSERT_SVH
`define CANDIDATE_KEY_DEDUP_RING_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CKDR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define CKDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CKDR_ASSERT(lbl, ante, cons, msg)
`define CKDR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/ckdr_pkg.sv @@
// ----------------------------------------------------------------------------
// ckdr_pkg
// Shared sizes, types and helpers of the candidate key dedup ring.
// ----------------------------------------------------------------------------
package ckdr_pkg;

  localparam int MAX_KEY_BYTES = 32;
  localparam int SLOTS         = 1024;
  localparam int HASH_BITS     = 10;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LINK_W  = $clog2(SLOTS + 1);
  localparam int CNT_W   = 11;
  localparam int KL_W    = 6;
  localparam int POS_W   = $clog2(MAX_KEY_BYTES + 2);
  localparam int PADDR_W = 3;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

  typedef logic [MAX_KEY_BYTES-1:0][7:0] key_t;

  typedef enum logic [0:0] {
    REG_KEY_LENGTH = 1'b0,
    REG_BATCH_SIZE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic                 done;
    logic [HASH_BITS-1:0] bucket;
  } hash_res_t;

  // key_length clamped to 1..MAX_KEY_BYTES
  function automatic logic [POS_W-1:0] eff_len(logic [KL_W-1:0] kl);
    logic [POS_W-1:0] r;
    r = POS_W'(kl);
    if (kl == '0) begin
      r = POS_W'(1);
    end else if (POS_W'(kl) > POS_W'(MAX_KEY_BYTES)) begin
      r = POS_W'(MAX_KEY_BYTES);
    end
    return r;
  endfunction

endpackage

@@ rtl/ckdr_hash.sv @@
// ----------------------------------------------------------------------------
// ckdr_hash
// Iterative alternating-sum bucket hash, two key bytes per cycle.
// ----------------------------------------------------------------------------
module ckdr_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ckdr_pkg::key_t     key_i,
  input  logic [ckdr_pkg::POS_W-1:0] len_i,
  output ckdr_pkg::hash_res_t res_o
);
  import ckdr_pkg::*;

  logic                 run_q;
  key_t                 hk_q;
  logic [HASH_BITS-1:0] hacc_q, eacc_q;
  logic [POS_W-1:0]     pos_q, len_q;
  hash_res_t            res_q;

  logic [7:0]           x, y;
  logic                 stop1, stop2, odd;
  logic [HASH_BITS-1:0] h_add, fin_h, fin;

  assign x     = hk_q[2];
  assign y     = hk_q[3];
  assign odd   = len_q[0];
  assign stop1 = odd ? (x == 8'd0) : (x == 8'd0 || pos_q >= len_q);
  assign stop2 = odd ? (y == 8'd0 || pos_q >= len_q) : (y == 8'd0);
  assign h_add = hacc_q + HASH_BITS'(x);
  assign fin_h = stop1 ? hacc_q : h_add;
  assign fin   = (fin_h - (eacc_q + HASH_BITS'(pos_q))) ^
                 ((HASH_BITS > 6) ? (eacc_q << 6) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      res_q <= '0;
    end else begin
      if (start_i) begin
        if (key_i[0] == 8'd0) begin
          res_q <= '{done: 1'b1, bucket: '0};
        end else if (key_i[1] == 8'd0) begin
          res_q <= '{done: 1'b1, bucket: HASH_BITS'(key_i[0])};
        end else begin
          run_q      <= 1'b1;
          res_q.done <= 1'b0;
        end
      end else if (run_q && (stop1 || stop2)) begin
        run_q <= 1'b0;
        res_q <= '{done: 1'b1, bucket: fin};
      end else begin
        res_q.done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hk_q   <= key_i;
      hacc_q <= HASH_BITS'(key_i[0]);
      eacc_q <= HASH_BITS'(key_i[1]);
      pos_q  <= POS_W'(3);
      len_q  <= len_i;
    end else if (run_q && !stop1 && !stop2) begin
      hk_q   <= hk_q >> 16;
      hacc_q <= h_add;
      eacc_q <= eacc_q + HASH_BITS'(y);
      pos_q  <= pos_q + POS_W'(2);
    end
  end

  assign res_o = res_q;

endmodule

@@ rtl/candidate_key_dedup_ring_core.sv @@
// ----------------------------------------------------------------------------
// candidate_key_dedup_ring_core
// Duplicate filter for candidate keys: hash-chained table over a ring of
// key slots, with batch fill accounting.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+------------------
//  key in    | key_byte_i last_byte_i from_guesses_i      | start && !busy
//  result    | accepted_o slot_o batch_full_o             | result_valid_o,
//            | batch_guess_count_o                        | one cycle, no stall
//  config    | psel penable pwrite paddr pwdata prdata    | APB, pready tied 1
//
//  Key bytes are taken one per cycle while idle. After the last byte the
//  block is busy: hash, then lookup comparing one chain entry at a time
//  (single read port on the key store); a duplicate ends there. Else the
//  slot is unlinked (skipped for an empty slot, else its bucket chain is
//  walked), then inserted. The result shows in the cycle after the decision.
//  After reset all bucket heads are swept to empty while busy is high.
//  Results cannot be stalled; each item with last_byte gives exactly one.
// ----------------------------------------------------------------------------
`include "candidate_key_dedup_ring_core_assert.svh"

module candidate_key_dedup_ring_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ckdr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    key_byte_i,
  input  logic                          last_byte_i,
  input  logic                          from_guesses_i,
  output logic                          result_valid_o,
  output logic                          accepted_o,
  output logic [ckdr_pkg::SLOT_W-1:0]   slot_o,
  output logic                          batch_full_o,
  output logic [ckdr_pkg::CNT_W-1:0]    batch_guess_count_o
);
  import ckdr_pkg::*;

  typedef enum logic [11:0] {
    ST_CLEAR  = 12'b0000_0000_0001,
    ST_IDLE   = 12'b0000_0000_0010,
    ST_HASH   = 12'b0000_0000_0100,
    ST_LOOK   = 12'b0000_0000_1000,
    ST_LOOK_W = 12'b0000_0001_0000,
    ST_CMP    = 12'b0000_0010_0000,
    ST_UNL    = 12'b0000_0100_0000,
    ST_UNL_B  = 12'b0000_1000_0000,
    ST_UNL_H  = 12'b0001_0000_0000,
    ST_UNL_W  = 12'b0010_0000_0000,
    ST_INS    = 12'b0100_0000_0000,
    ST_INS_W  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // ---- configuration registers ----
  logic [KL_W-1:0]  key_len_q;
  logic [CNT_W-1:0] batch_q;
  logic             cfg_we;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_KEY_LENGTH: prdata = 32'(key_len_q);
      REG_BATCH_SIZE: prdata = 32'(batch_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= KL_W'(32);
      batch_q   <= CNT_W'(1024);
    end else if (cfg_we) begin
      if (cfg_idx == REG_KEY_LENGTH) begin
        key_len_q <= pwdata[KL_W-1:0];
      end else begin
        batch_q <= pwdata[CNT_W-1:0];
      end
    end
  end

  // ---- byte intake ----
  key_t             ik_q, ik_w, cand_w, cand_q;
  logic [POS_W-1:0] bp_q, eff_now, eff_q;
  logic             alive_q, store_b, take;

  assign busy    = (state_q != ST_IDLE);
  assign take    = start && !busy;
  assign eff_now = eff_len(key_len_q);
  // a byte lands only inside the length and before any zero byte
  assign store_b = (bp_q < eff_now) && alive_q;

  always_comb begin
    ik_w = ik_q;
    if (store_b) begin
      ik_w[bp_q[$clog2(MAX_KEY_BYTES)-1:0]] = key_byte_i;
    end
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      cand_w[i] = (POS_W'(i) < eff_now) ? ik_w[i] : 8'd0;
    end
  end

  // ---- slot / batch bookkeeping ----
  logic [CNT_W-1:0]  fill_q, tally_q, hw_q;
  logic [SLOT_W-1:0] s_q;
  logic              guess_q;

  // ---- hash unit ----
  hash_res_t         hres;
  logic [SLOT_W-1:0] bucket_q, bucket_d;

  ckdr_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (take && last_byte_i),
    .key_i   (cand_w),
    .len_i   (eff_now),
    .res_o   (hres)
  );

  // ---- memories ----
  logic [LINK_W-1:0] heads_mem [SLOTS];
  logic [LINK_W-1:0] next_mem  [SLOTS];
  logic [SLOT_W-1:0] sb_mem    [SLOTS];
  key_t              key_mem   [SLOTS];

  logic              heads_we, next_we, ins_we;
  logic [SLOT_W-1:0] heads_ra, heads_wa, next_ra, next_wa, sb_ra, key_ra;
  logic [LINK_W-1:0] heads_wd, next_wd, heads_rd, next_rd;
  logic [SLOT_W-1:0] sb_rd;
  key_t              key_rd;

  always_ff @(posedge clk_i) begin
    if (heads_we) begin
      heads_mem[heads_wa] <= heads_wd;
    end
    heads_rd <= heads_mem[heads_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd <= next_mem[next_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ins_we) begin
      sb_mem[s_q] <= bucket_q;
    end
    sb_rd <= sb_mem[sb_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ins_we) begin
      key_mem[s_q] <= cand_q;
    end
    key_rd <= key_mem[key_ra];
  end

  // stored keys are zero past their length, so compare only the live bytes
  logic key_match;
  always_comb begin
    key_match = 1'b1;
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      if (POS_W'(i) < eff_q && key_rd[i] != cand_q[i]) begin
        key_match = 1'b0;
      end
    end
  end

  // ---- sequencer ----
  logic [SLOT_W-1:0] idx_q, idx_d, bk_q, bk_d, clr_q, clr_d;
  logic [LINK_W-1:0] steps_q, steps_d, nxs_q, nxs_d;
  logic              emit, emit_acc;
  logic [LINK_W-1:0] s_link;

  assign s_link = {1'b0, s_q};

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    steps_d  = steps_q;
    bk_d     = bk_q;
    nxs_d    = nxs_q;
    clr_d    = clr_q;
    bucket_d = bucket_q;
    heads_ra = bucket_q;
    next_ra  = idx_q;
    key_ra   = idx_q;
    sb_ra    = s_q;
    heads_we = 1'b0;
    heads_wa = bucket_q;
    heads_wd = s_link;
    next_we  = 1'b0;
    next_wa  = s_q;
    next_wd  = heads_rd;
    ins_we   = 1'b0;
    emit     = 1'b0;
    emit_acc = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        heads_we = 1'b1;
        heads_wa = clr_q;
        heads_wd = NIL;
        clr_d    = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take && last_byte_i) begin
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hres.done) begin
          bucket_d = hres.bucket;
          state_d  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_LOOK_W;
      end
      ST_LOOK_W: begin
        if (heads_rd >= NIL) begin
          state_d = ST_UNL;
        end else begin
          idx_d   = heads_rd[SLOT_W-1:0];
          key_ra  = heads_rd[SLOT_W-1:0];
          next_ra = heads_rd[SLOT_W-1:0];
          steps_d = '0;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (key_match) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          steps_d = steps_q + LINK_W'(1);
          if (next_rd >= NIL || steps_q == LINK_W'(SLOTS - 1)) begin
            state_d = ST_UNL;
          end else begin
            idx_d   = next_rd[SLOT_W-1:0];
            key_ra  = next_rd[SLOT_W-1:0];
            next_ra = next_rd[SLOT_W-1:0];
          end
        end
      end
      ST_UNL: begin
        // slots below the high-water mark hold a key
        if (CNT_W'(s_q) < hw_q) begin
          sb_ra   = s_q;
          next_ra = s_q;
          state_d = ST_UNL_B;
        end else begin
          state_d = ST_INS;
        end
      end
      ST_UNL_B: begin
        bk_d     = sb_rd;
        nxs_d    = next_rd;
        heads_ra = sb_rd;
        state_d  = ST_UNL_H;
      end
      ST_UNL_H: begin
        if (heads_rd == s_link) begin
          heads_we = 1'b1;
          heads_wa = bk_q;
          heads_wd = nxs_q;
          state_d  = ST_INS;
        end else if (heads_rd >= NIL) begin
          state_d = ST_INS;
        end else begin
          idx_d   = heads_rd[SLOT_W-1:0];
          next_ra = heads_rd[SLOT_W-1:0];
          steps_d = '0;
          state_d = ST_UNL_W;
        end
      end
      ST_UNL_W: begin
        if (next_rd == s_link) begin
          next_we = 1'b1;
          next_wa = idx_q;
          next_wd = nxs_q;
          state_d = ST_INS;
        end else begin
          steps_d = steps_q + LINK_W'(1);
          if (next_rd >= NIL || steps_q == LINK_W'(SLOTS - 1)) begin
            state_d = ST_INS;
          end else begin
            idx_d   = next_rd[SLOT_W-1:0];
            next_ra = next_rd[SLOT_W-1:0];
          end
        end
      end
      ST_INS: begin
        // re-read the head, the unlink may have moved it
        state_d = ST_INS_W;
      end
      ST_INS_W: begin
        next_we  = 1'b1;
        next_wa  = s_q;
        next_wd  = heads_rd;
        heads_we = 1'b1;
        heads_wa = bucket_q;
        heads_wd = s_link;
        ins_we   = 1'b1;
        emit     = 1'b1;
        emit_acc = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---- batch accounting ----
  logic [CNT_W-1:0] fill_new, tally_new, bs_eff;
  logic             full;

  assign fill_new  = CNT_W'(s_q) + CNT_W'(1);
  assign tally_new = tally_q + CNT_W'(guess_q);
  assign bs_eff    = (batch_q == '0) ? CNT_W'(1) :
                     (batch_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : batch_q;
  assign full      = (fill_new >= bs_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      ik_q           <= '0;
      bp_q           <= '0;
      alive_q        <= 1'b1;
      fill_q         <= '0;
      tally_q        <= '0;
      hw_q           <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      result_valid_o <= emit;
      if (take) begin
        if (last_byte_i) begin
          ik_q    <= '0;
          bp_q    <= '0;
          alive_q <= 1'b1;
        end else begin
          ik_q    <= ik_w;
          bp_q    <= (bp_q < POS_W'(MAX_KEY_BYTES)) ? bp_q + POS_W'(1) : bp_q;
          alive_q <= store_b && (key_byte_i != 8'd0);
        end
      end
      if (emit_acc) begin
        if (fill_new > hw_q) begin
          hw_q <= fill_new;
        end
        fill_q  <= full ? '0 : fill_new;
        tally_q <= full ? '0 : tally_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    steps_q  <= steps_d;
    bk_q     <= bk_d;
    nxs_q    <= nxs_d;
    bucket_q <= bucket_d;
    if (take && last_byte_i) begin
      cand_q  <= cand_w;
      eff_q   <= eff_now;
      guess_q <= from_guesses_i;
      s_q     <= (fill_q >= CNT_W'(SLOTS)) ? SLOT_W'(SLOTS - 1) : fill_q[SLOT_W-1:0];
    end
    accepted_o          <= emit_acc;
    slot_o              <= emit_acc ? s_q : '0;
    batch_full_o        <= emit_acc && full;
    batch_guess_count_o <= (emit_acc && full) ? tally_new : '0;
  end

  // ---- checks ----
  `CKDR_ASSERT(a_reject_clean, result_valid_o && !accepted_o, slot_o == '0 && !batch_full_o, "reject with payload")
  `CKDR_ASSERT(a_full_resets, result_valid_o && batch_full_o, fill_q == '0 && tally_q == '0, "batch not restarted")
  `CKDR_ASSERT_NEXT(a_last_busy, start && !busy && last_byte_i, busy, "key end not processed")

endmodule

@@ verif/candidate_key_dedup_ring_core_tb.sv @@
// ----------------------------------------------------------------------------
// candidate_key_dedup_ring_core_tb
// Drives candidate keys byte by byte under random bursts and gaps, checks
// every verdict against a built-in model of the hash-chained dedup table,
// and walks key_length and batch_size through several settings over APB.
// ----------------------------------------------------------------------------
module candidate_key_dedup_ring_core_tb;
  import ckdr_pkg::*;

  typedef struct {
    bit        accepted;
    bit [9:0]  slot;
    bit        full;
    bit [10:0] guesses;
  } verdict_t;

  // Model of the dedup table; holds the verdicts still owed by the block.
  class dedup_scoreboard;
    int unsigned key_len, batch_len;
    int unsigned heads[SLOTS];
    int unsigned links[SLOTS];
    bit          used[SLOTS];
    int unsigned owner[SLOTS];
    bit [7:0]    store[SLOTS][MAX_KEY_BYTES];
    int unsigned fill, tally, pos;
    bit [7:0]    incoming[MAX_KEY_BYTES];
    bit [7:0]    cand[MAX_KEY_BYTES];
    int unsigned eff;
    verdict_t    owed[$];
    int          errors;

    function new();
      key_len = 32;
      batch_len = 1024;
      foreach (heads[i]) heads[i] = SLOTS;
      foreach (links[i]) begin
        links[i] = 0;
        used[i] = 0;
        owner[i] = 0;
        for (int j = 0; j < MAX_KEY_BYTES; j++) store[i][j] = 0;
      end
      foreach (incoming[i]) incoming[i] = 0;
      fill = 0;
      tally = 0;
      pos = 0;
      errors = 0;
    endfunction

    function int unsigned kb(int unsigned i);
      return (i < eff) ? int'(cand[i]) : 0;
    endfunction

    // alternating-sum bucket hash
    function int unsigned bucket_of();
      int unsigned h, e, p, b;
      h = kb(0);
      p = 3;
      b = 0;
      if (h == 0) return 0;
      e = kb(1);
      if (e == 0) return h & ((1 << HASH_BITS) - 1);
      if (eff & 1) begin
        while (kb(b + 2) != 0) begin
          h += kb(b + 2);
          if (kb(b + 3) == 0 || p >= eff) break;
          e += kb(b + 3);
          b += 2;
          p += 2;
        end
      end else begin
        while (kb(b + 2) != 0 && p < eff) begin
          h += kb(b + 2);
          if (kb(b + 3) == 0) break;
          e += kb(b + 3);
          b += 2;
          p += 2;
        end
      end
      h -= e + p;
      h ^= e << 6;
      return h & ((1 << HASH_BITS) - 1);
    endfunction

    function bit same_key(int unsigned s);
      for (int unsigned i = 0; i < eff; i++)
        if (cand[i] != store[s][i]) return 0;
      return 1;
    endfunction

    function void unlink(int unsigned s);
      int unsigned bk, idx, steps, nx;
      bk = owner[s];
      idx = heads[bk];
      steps = 0;
      if (idx == s) begin
        heads[bk] = links[s];
        return;
      end
      while (idx < SLOTS && steps < SLOTS) begin
        nx = links[idx];
        if (nx == s) begin
          links[idx] = links[s];
          return;
        end
        idx = nx;
        steps++;
      end
    endfunction

    function void note_byte(bit [7:0] b, bit last, bit guess);
      int unsigned h, idx, steps, s, batch;
      bit dup;
      verdict_t v;
      eff = (key_len == 0) ? 1 : (key_len > MAX_KEY_BYTES ? MAX_KEY_BYTES : key_len);
      if (pos < eff && (pos == 0 || incoming[pos-1] != 0)) incoming[pos] = b;
      if (pos < MAX_KEY_BYTES) pos++;
      if (!last) return;
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        cand[i] = (i < eff) ? incoming[i] : 8'h00;
        incoming[i] = 0;
      end
      pos = 0;
      h = bucket_of();
      idx = heads[h];
      steps = 0;
      dup = 0;
      while (idx < SLOTS && steps < SLOTS) begin
        if (same_key(idx)) begin
          dup = 1;
          break;
        end
        idx = links[idx];
        steps++;
      end
      v = '{0, 0, 0, 0};
      if (!dup) begin
        s = (fill >= SLOTS) ? SLOTS - 1 : fill;
        if (used[s]) unlink(s);
        links[s] = heads[h];
        heads[h] = s;
        owner[s] = h;
        used[s] = 1;
        foreach (cand[i]) store[s][i] = cand[i];
        tally = (tally + guess) & 11'h7ff;
        fill = s + 1;
        batch = (batch_len == 0) ? 1 : (batch_len > SLOTS ? SLOTS : batch_len);
        v.accepted = 1;
        v.slot = s[9:0];
        if (fill >= batch) begin
          v.full = 1;
          v.guesses = tally[10:0];
          fill = 0;
          tally = 0;
        end
      end
      owed.push_back(v);
    endfunction

    function void check_verdict(bit acc, bit [9:0] slot, bit full, bit [10:0] cnt);
      verdict_t v;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected verdict acc=%0d slot=%0d", acc, slot);
        return;
      end
      v = owed.pop_front();
      if (v.accepted != acc || v.slot != slot || v.full != full || v.guesses != cnt) begin
        errors++;
        if (errors <= 10)
          $display("verdict mismatch: exp acc=%0d slot=%0d full=%0d guesses=%0d, %s %0d %0d %0d %0d",
                   v.accepted, v.slot, v.full, v.guesses, "got", acc, slot, full, cnt);
      end
    endfunction
  endclass

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 start = 0;
  logic                 busy;
  logic [7:0]           key_byte_i = '0;
  logic                 last_byte_i = 0;
  logic                 from_guesses_i = 0;
  logic                 result_valid_o, accepted_o, batch_full_o;
  logic [SLOT_W-1:0]    slot_o;
  logic [CNT_W-1:0]     batch_guess_count_o;

  candidate_key_dedup_ring_core uut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  dedup_scoreboard sb = new();
  int               burst_left = 0;
  int               stall_cycles = 0;
  bit [7:0]         pool[64][40];
  int               pool_len[64];
  bit [7:0]         kbuf[40];

  // verdicts cannot be held off: sample on every edge
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_verdict(accepted_o, slot_o, batch_full_o, batch_guess_count_o);
  end

  // watchdog on cycles with neither a byte taken nor a verdict
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_byte(bit [7:0] b, bit last, bit guess);
    if (burst_left == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      // occasional long stretch with no gaps
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    start          <= 1;
    key_byte_i     <= b;
    last_byte_i    <= last;
    from_guesses_i <= guess;
    do @(posedge clk_i); while (busy);
    sb.note_byte(b, last, guess);
    burst_left--;
  endtask

  task automatic send_key(int n, bit guess);
    for (int i = 0; i < n; i++) send_byte(kbuf[i], i == n - 1, guess);
  endtask

  // sender stops, all verdicts in, then a margin for trailing bytes
  task automatic drain();
    start <= 0;
    burst_left = 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e r, int unsigned v);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= PADDR_W'({r, 2'b00});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel    <= 0;
    penable <= 0;
    if (r == REG_KEY_LENGTH) sb.key_len = v & 6'h3f;
    else sb.batch_len = v & 11'h7ff;
  endtask

  task automatic random_key();
    int p, n;
    bit guess;
    p = $urandom_range(0, 63);
    guess = $urandom_range(0, 1);
    if (pool_len[p] != 0 && $urandom_range(0, 9) < 4) begin
      // repeat of an earlier key: duplicate path
      n = pool_len[p];
      for (int i = 0; i < n; i++) kbuf[i] = pool[p][i];
    end else begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      for (int i = 0; i < n; i++)
        kbuf[i] = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      pool_len[p] = n;
      for (int i = 0; i < n; i++) pool[p][i] = kbuf[i];
    end
    send_key(n, guess);
  endtask

  initial begin
    int lens[8];
    int sizes[8];
    lens  = '{32, 1, 8, 0, 63, 4, 16, 16};
    sizes = '{1024, 1, 16, 0, 2047, 5, 1000, 3};
    foreach (pool_len[i]) pool_len[i] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;

    // directed: extreme bytes, zero byte, long key, duplicate, guess flag
    for (int i = 0; i < 32; i++) kbuf[i] = 8'hff;
    send_key(32, 1);
    kbuf[0] = 8'h00;
    send_key(1, 0);
    kbuf[0] = 8'h41; kbuf[1] = 8'h00; kbuf[2] = 8'h42;
    send_key(3, 1);
    kbuf[0] = 8'h41;
    send_key(1, 0);
    for (int i = 0; i < 40; i++) kbuf[i] = 8'(i + 1);
    send_key(40, 0);
    send_key(32, 1);
    kbuf[0] = 8'h80; kbuf[1] = 8'h01; kbuf[2] = 8'h7f; kbuf[3] = 8'hfe;
    send_key(4, 1);
    send_key(4, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_KEY_LENGTH, lens[ph]);
      write_reg(REG_BATCH_SIZE, sizes[ph]);
      for (int k = 0; k < 22; k++) random_key();
      drain();
    end

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
